FILE: rtl/cci_pkg.sv
// ---------------------------------------------------------------------------
// cci_pkg: shared types and constants for the circle contact impulse block
// Item layouts, pipeline depths and fixed-point constants.
// ---------------------------------------------------------------------------
`default_nettype none

package cci_pkg;

  localparam logic [15:0] RESTITUTION_RESET = 16'd26214;
  localparam logic [16:0] ONE_Q15           = 17'd32768;
  localparam logic [30:0] ONE_Q30           = 31'd1073741824;
  localparam logic [32:0] ONE_Q32           = 33'h1_0000_0000;
  // 1e-6 in Q32.32
  localparam logic [14:0] DIST_EPS_Q32      = 15'd4294;
  // Largest magnitude whose square can still sit under the epsilon
  localparam logic [32:0] DEG_LIM           = 33'd65;

  localparam int unsigned FRONT_STAGES = 6;
  localparam int unsigned SQRT_STEPS   = 32;
  localparam int unsigned DIV_STEPS    = 33;
  localparam int unsigned IMP_STAGES   = 8;
  localparam int unsigned LATENCY      = FRONT_STAGES + SQRT_STEPS + DIV_STEPS + IMP_STAGES;

  typedef enum logic [1:0] {
    OUT_IMPULSE    = 2'd0,
    OUT_SEPARATING = 2'd1,
    OUT_STATIC     = 2'd2
  } outcome_e;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic        [31:0] mass_a;
    logic        [31:0] mass_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    outcome_e           outcome;
  } out_t;

  typedef struct packed {
    logic signed [31:0] vel_ax;
    logic signed [31:0] vel_ay;
    logic signed [31:0] vel_bx;
    logic signed [31:0] vel_by;
    logic signed [32:0] dvx;
    logic signed [32:0] dvy;
    logic        [31:0] ma;
    logic        [31:0] mb;
  } carry_t;

  typedef struct packed {
    carry_t      c;
    logic [30:0] ux;
    logic [30:0] uy;
    logic        negx;
    logic        negy;
    logic        deg;
  } front_t;

  typedef struct packed {
    logic signed [31:0] vel_ax;
    logic signed [31:0] vel_ay;
    logic signed [31:0] vel_bx;
    logic signed [31:0] vel_by;
    logic signed [32:0] dvx;
    logic signed [32:0] dvy;
    logic               negx;
    logic               negy;
    logic               deg;
    logic               ma0;
    logic               mb0;
  } mid_t;

endpackage

`default_nettype wire

FILE: rtl/cci_in_if.sv
// ---------------------------------------------------------------------------
// cci_in_if: contact pair channel
// Valid/ready handshake carrying one contact pair per item.
// ---------------------------------------------------------------------------
`default_nettype none

interface cci_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_a_x;
  logic signed [31:0] pos_a_y;
  logic signed [31:0] pos_b_x;
  logic signed [31:0] pos_b_y;
  logic signed [31:0] vel_a_x;
  logic signed [31:0] vel_a_y;
  logic signed [31:0] vel_b_x;
  logic signed [31:0] vel_b_y;
  logic        [31:0] mass_a;
  logic        [31:0] mass_b;

  modport source (
    output valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
           vel_a_x, vel_a_y, vel_b_x, vel_b_y, mass_a, mass_b,
    input  ready
  );
  modport sink (
    input  valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
           vel_a_x, vel_a_y, vel_b_x, vel_b_y, mass_a, mass_b,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/cci_out_if.sv
// ---------------------------------------------------------------------------
// cci_out_if: velocity response channel
// Valid/ready handshake carrying the updated velocities and the outcome.
// ---------------------------------------------------------------------------
`default_nettype none

interface cci_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_vel_a_x;
  logic signed [31:0] new_vel_a_y;
  logic signed [31:0] new_vel_b_x;
  logic signed [31:0] new_vel_b_y;
  logic        [1:0]  outcome;

  modport source (
    output valid, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y, outcome,
    input  ready
  );
  modport sink (
    input  valid, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y, outcome,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/cci_front.sv
// ---------------------------------------------------------------------------
// cci_front: separation vector and normalisation
// Six stages: differences, magnitudes, shift search, shift, squares, sum.
// ---------------------------------------------------------------------------
`default_nettype none

module cci_front (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire cci_pkg::in_t   pair_i,
  output logic [62:0]         s_o,
  output cci_pkg::front_t     side_o
);

  cci_pkg::carry_t c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic signed [32:0] dx1_q, dy1_q;
  logic [32:0] ux2_q, uy2_q, ux3_q, uy3_q;
  logic        nx2_q, ny2_q, nx3_q, ny3_q, nx4_q, ny4_q, nx5_q, ny5_q, nx6_q, ny6_q;
  logic        dg3_q, dg4_q, dg5_q, dg6_q;
  logic [1:0]  rsh3_q;
  logic [4:0]  lsh3_q;
  logic [30:0] un4x_q, un4y_q, un5x_q, un5y_q, un6x_q, un6y_q;
  logic [61:0] sq5x_q, sq5y_q;
  logic [62:0] s6_q;

  cci_pkg::carry_t c1_d;
  logic [32:0] ux2_d, uy2_d, or3;
  logic [13:0] sqx7, sqy7;
  logic [14:0] sqsum7;
  logic        dg3_d;
  logic [1:0]  rsh3_d;
  logic [4:0]  lsh3_d;
  logic [32:0] shx, shy;

  always_comb begin
    c1_d.vel_ax = pair_i.vel_a_x;
    c1_d.vel_ay = pair_i.vel_a_y;
    c1_d.vel_bx = pair_i.vel_b_x;
    c1_d.vel_by = pair_i.vel_b_y;
    c1_d.dvx    = {pair_i.vel_b_x[31], pair_i.vel_b_x} - {pair_i.vel_a_x[31], pair_i.vel_a_x};
    c1_d.dvy    = {pair_i.vel_b_y[31], pair_i.vel_b_y} - {pair_i.vel_a_y[31], pair_i.vel_a_y};
    c1_d.ma     = pair_i.mass_a;
    c1_d.mb     = pair_i.mass_b;
  end

  always_comb begin
    ux2_d = dx1_q[32] ? 33'(-dx1_q) : dx1_q;
    uy2_d = dy1_q[32] ? 33'(-dy1_q) : dy1_q;
  end

  // The leading one of the larger magnitude is the leading one of the OR
  always_comb begin
    or3    = ux2_q | uy2_q;
    sqx7   = ux2_q[6:0] * ux2_q[6:0];
    sqy7   = uy2_q[6:0] * uy2_q[6:0];
    sqsum7 = {1'b0, sqx7} + {1'b0, sqy7};
    dg3_d  = (ux2_q <= cci_pkg::DEG_LIM) && (uy2_q <= cci_pkg::DEG_LIM) &&
             (sqsum7 <= cci_pkg::DIST_EPS_Q32);
    rsh3_d = or3[32] ? 2'd2 : (or3[31] ? 2'd1 : 2'd0);
    lsh3_d = '0;
    for (int i = 0; i <= 30; i++) begin
      if (or3[i]) lsh3_d = 5'(30 - i);
    end
  end

  always_comb begin
    if (rsh3_q != 2'd0) begin
      shx = ux3_q >> rsh3_q;
      shy = uy3_q >> rsh3_q;
    end else begin
      shx = ux3_q << lsh3_q;
      shy = uy3_q << lsh3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q   <= c1_d;
      dx1_q  <= {pair_i.pos_b_x[31], pair_i.pos_b_x} - {pair_i.pos_a_x[31], pair_i.pos_a_x};
      dy1_q  <= {pair_i.pos_b_y[31], pair_i.pos_b_y} - {pair_i.pos_a_y[31], pair_i.pos_a_y};

      c2_q   <= c1_q;
      ux2_q  <= ux2_d;
      uy2_q  <= uy2_d;
      nx2_q  <= dx1_q[32];
      ny2_q  <= dy1_q[32];

      c3_q   <= c2_q;
      ux3_q  <= ux2_q;
      uy3_q  <= uy2_q;
      nx3_q  <= nx2_q;
      ny3_q  <= ny2_q;
      dg3_q  <= dg3_d;
      rsh3_q <= rsh3_d;
      lsh3_q <= lsh3_d;

      c4_q   <= c3_q;
      un4x_q <= shx[30:0];
      un4y_q <= shy[30:0];
      nx4_q  <= nx3_q;
      ny4_q  <= ny3_q;
      dg4_q  <= dg3_q;

      c5_q   <= c4_q;
      sq5x_q <= un4x_q * un4x_q;
      sq5y_q <= un4y_q * un4y_q;
      un5x_q <= un4x_q;
      un5y_q <= un4y_q;
      nx5_q  <= nx4_q;
      ny5_q  <= ny4_q;
      dg5_q  <= dg4_q;

      c6_q   <= c5_q;
      s6_q   <= {1'b0, sq5x_q} + {1'b0, sq5y_q};
      un6x_q <= un5x_q;
      un6y_q <= un5y_q;
      nx6_q  <= nx5_q;
      ny6_q  <= ny5_q;
      dg6_q  <= dg5_q;
    end
  end

  assign s_o         = s6_q;
  assign side_o.c    = c6_q;
  assign side_o.ux   = un6x_q;
  assign side_o.uy   = un6y_q;
  assign side_o.negx = nx6_q;
  assign side_o.negy = ny6_q;
  assign side_o.deg  = dg6_q;

endmodule

`default_nettype wire

FILE: rtl/cci_isqrt.sv
// ---------------------------------------------------------------------------
// cci_isqrt: pipelined integer square root
// One root bit per stage, restoring remainder form, 32 stages.
// ---------------------------------------------------------------------------
`default_nettype none

module cci_isqrt (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [62:0] s_i,
  output logic [31:0]      root_o
);

  logic [63:0] rem_q  [cci_pkg::SQRT_STEPS];
  logic [31:0] root_q [cci_pkg::SQRT_STEPS];

  for (genvar j = 0; j < cci_pkg::SQRT_STEPS; j++) begin : g_step
    localparam int unsigned B = cci_pkg::SQRT_STEPS - 1 - j;
    logic [63:0] rem_in, rem_d;
    logic [31:0] root_in, root_d;
    logic [65:0] trial;

    if (j == 0) begin : g_first
      assign rem_in  = {1'b0, s_i};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
    always_comb begin
      trial  = ({34'd0, root_in} << (B + 1)) + (66'd1 << (2 * B));
      rem_d  = rem_in;
      root_d = root_in;
      if ({2'b00, rem_in} >= trial) begin
        rem_d  = rem_in - trial[63:0];
        root_d = root_in | (32'd1 << B);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
      end
    end
  end

  assign root_o = root_q[cci_pkg::SQRT_STEPS-1];

endmodule

`default_nettype wire

FILE: rtl/cci_udiv.sv
// ---------------------------------------------------------------------------
// cci_udiv: pipelined unsigned divider
// 64-bit dividend over 33-bit divisor, one quotient bit per stage, 33 stages.
// The dividend must stay below divisor * 2^33.
// ---------------------------------------------------------------------------
`default_nettype none

module cci_udiv (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] num_i,
  input  wire logic [32:0] den_i,
  output logic [32:0]      quo_o,
  output logic [32:0]      rem_o
);

  logic [63:0] rem_q [cci_pkg::DIV_STEPS];
  logic [32:0] den_q [cci_pkg::DIV_STEPS];
  logic [32:0] quo_q [cci_pkg::DIV_STEPS];

  for (genvar j = 0; j < cci_pkg::DIV_STEPS; j++) begin : g_step
    localparam int unsigned B = cci_pkg::DIV_STEPS - 1 - j;
    logic [63:0] rem_in, rem_d;
    logic [32:0] den_in, quo_in, quo_d;
    logic [65:0] trial;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    always_comb begin
      trial = {33'd0, den_in} << B;
      rem_d = rem_in;
      quo_d = quo_in;
      if ({2'b00, rem_in} >= trial) begin
        rem_d = rem_in - trial[63:0];
        quo_d = quo_in | (33'd1 << B);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        den_q[j] <= den_in;
        quo_q[j] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[cci_pkg::DIV_STEPS-1];
  assign rem_o = rem_q[cci_pkg::DIV_STEPS-1][32:0];

endmodule

`default_nettype wire

FILE: rtl/cci_impulse.sv
// ---------------------------------------------------------------------------
// cci_impulse: approach speed, impulse and velocity update
// Eight stages: normal and weights, products, approach speed, classify,
// impulse, per-axis impulse, share, apply and saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module cci_impulse (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [15:0]   restitution_i,
  input  wire logic [30:0]   qx_i,
  input  wire logic [30:0]   qy_i,
  input  wire logic [32:0]   qw_i,
  input  wire logic          wrem_nz_i,
  input  wire cci_pkg::mid_t mid_i,
  output cci_pkg::out_t      res_o
);

  typedef struct packed {
    logic signed [31:0] vel_ax;
    logic signed [31:0] vel_ay;
    logic signed [31:0] vel_bx;
    logic signed [31:0] vel_by;
    logic               negx;
    logic               negy;
    logic [30:0]        nxm;
    logic [30:0]        nym;
    logic [32:0]        wa;
    logic [32:0]        wb;
  } imp_t;

  imp_t a_q, b_q, c_q, d_q, e_q, f_q, g_q;
  logic signed [32:0] dvxa_q, dvya_q;
  logic ma0a_q, mb0a_q, ma0b_q, mb0b_q, ma0c_q, mb0c_q;
  logic signed [63:0] px_q, py_q, van_q;
  logic [62:0] mvan_q;
  cci_pkg::outcome_e oc_d_q, oc_e_q, oc_f_q, oc_g_q;
  logic [34:0] k_q, kx_q, ky_q;
  logic [34:0] dax_q, day_q, dbx_q, dby_q;
  cci_pkg::out_t res_q;

  imp_t a_d;
  logic signed [64:0] px_d, py_d;
  logic signed [63:0] sx, sy;
  cci_pkg::outcome_e oc_d;
  logic [16:0] fac;
  logic [79:0] kp;
  logic [65:0] kxp, kyp;
  logic [67:0] daxp, dayp, dbxp, dbyp;

  always_comb begin
    a_d.vel_ax = mid_i.vel_ax;
    a_d.vel_ay = mid_i.vel_ay;
    a_d.vel_bx = mid_i.vel_bx;
    a_d.vel_by = mid_i.vel_by;
    a_d.negx   = mid_i.negx & ~mid_i.deg;
    a_d.negy   = mid_i.negy & ~mid_i.deg;
    a_d.nxm    = mid_i.deg ? cci_pkg::ONE_Q30 : qx_i;
    a_d.nym    = mid_i.deg ? '0 : qy_i;
    // The two floored shares add to 2^32 less one unless the split is exact
    if (mid_i.ma0) begin
      a_d.wa = '0;
      a_d.wb = cci_pkg::ONE_Q32;
    end else if (mid_i.mb0) begin
      a_d.wa = cci_pkg::ONE_Q32;
      a_d.wb = '0;
    end else begin
      a_d.wa = qw_i;
      a_d.wb = cci_pkg::ONE_Q32 - qw_i - {32'd0, wrem_nz_i};
    end
  end

  always_comb begin
    px_d = dvxa_q * $signed({1'b0, a_q.nxm});
    py_d = dvya_q * $signed({1'b0, a_q.nym});
    sx   = b_q.negx ? -px_q : px_q;
    sy   = b_q.negy ? -py_q : py_q;
    if (van_q > 64'sd0) begin
      oc_d = cci_pkg::OUT_SEPARATING;
    end else if (ma0c_q && mb0c_q) begin
      oc_d = cci_pkg::OUT_STATIC;
    end else begin
      oc_d = cci_pkg::OUT_IMPULSE;
    end
    fac  = cci_pkg::ONE_Q15 + {1'b0, restitution_i};
    kp   = mvan_q * fac;
    kxp  = k_q * e_q.nxm;
    kyp  = k_q * e_q.nym;
    daxp = kx_q * f_q.wa;
    dayp = ky_q * f_q.wa;
    dbxp = kx_q * f_q.wb;
    dbyp = ky_q * f_q.wb;
  end

  function automatic logic signed [31:0] sat_sum(input logic signed [31:0] v,
                                                 input logic [34:0] dlt,
                                                 input logic add);
    logic signed [36:0] vv, dd, r;
    vv = {{5{v[31]}}, v};
    dd = {2'b00, dlt};
    r  = add ? vv + dd : vv - dd;
    if (r > 37'sh0_7FFF_FFFF) begin
      sat_sum = 32'sh7FFF_FFFF;
    end else if (r < -37'sh0_8000_0000) begin
      sat_sum = 32'sh8000_0000;
    end else begin
      sat_sum = r[31:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      dvxa_q <= mid_i.dvx;
      dvya_q <= mid_i.dvy;
      ma0a_q <= mid_i.ma0;
      mb0a_q <= mid_i.mb0;

      b_q    <= a_q;
      px_q   <= px_d[63:0];
      py_q   <= py_d[63:0];
      ma0b_q <= ma0a_q;
      mb0b_q <= mb0a_q;

      c_q    <= b_q;
      van_q  <= sx + sy;
      ma0c_q <= ma0b_q;
      mb0c_q <= mb0b_q;

      d_q    <= c_q;
      mvan_q <= 63'(-van_q);
      oc_d_q <= oc_d;

      e_q    <= d_q;
      k_q    <= kp[79:45];
      oc_e_q <= oc_d_q;

      f_q    <= e_q;
      kx_q   <= kxp[64:30];
      ky_q   <= kyp[64:30];
      oc_f_q <= oc_e_q;

      g_q    <= f_q;
      dax_q  <= daxp[66:32];
      day_q  <= dayp[66:32];
      dbx_q  <= dbxp[66:32];
      dby_q  <= dbyp[66:32];
      oc_g_q <= oc_f_q;

      res_q.outcome <= oc_g_q;
      if (oc_g_q == cci_pkg::OUT_IMPULSE) begin
        res_q.new_vel_a_x <= sat_sum(g_q.vel_ax, dax_q, g_q.negx);
        res_q.new_vel_a_y <= sat_sum(g_q.vel_ay, day_q, g_q.negy);
        res_q.new_vel_b_x <= sat_sum(g_q.vel_bx, dbx_q, ~g_q.negx);
        res_q.new_vel_b_y <= sat_sum(g_q.vel_by, dby_q, ~g_q.negy);
      end else begin
        res_q.new_vel_a_x <= g_q.vel_ax;
        res_q.new_vel_a_y <= g_q.vel_ay;
        res_q.new_vel_b_x <= g_q.vel_bx;
        res_q.new_vel_b_y <= g_q.vel_by;
      end
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: rtl/circle_contact_impulse.sv
// ---------------------------------------------------------------------------
// circle_contact_impulse: velocity response of a contact between two circles
// Top level: restitution register, valid pipeline and stage wiring.
// ---------------------------------------------------------------------------
// One contact pair enters per clock unless the output stalls; each passes
// 6 normalisation stages, a 32-stage square root, three 33-stage dividers
// running side by side (both normal components and the mass share) and
// 8 impulse stages, all sharing one advance enable. The whole pipeline holds
// while a result waits at the output; bubbles still drain while the output
// is empty. Write restitution only with no pair in flight.
`default_nettype none

module circle_contact_impulse (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  cci_in_if.sink           contact_i,
  cci_out_if.source        resp_o
);

  logic [15:0] restitution_q;
  logic [cci_pkg::LATENCY-1:0] vld_q;
  logic en;

  cci_pkg::in_t    pair;
  cci_pkg::front_t fside;
  cci_pkg::front_t line1_q [cci_pkg::SQRT_STEPS];
  cci_pkg::mid_t   mid_d;
  cci_pkg::mid_t   line2_q [cci_pkg::DIV_STEPS];
  cci_pkg::out_t   res;
  logic [62:0] s;
  logic [31:0] root;
  logic [32:0] qx, qy, qw, rx, ry, rw;
  logic [32:0] msum;

  assign en = ~vld_q[cci_pkg::LATENCY-1] | resp_o.ready;
  assign contact_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restitution_q <= cci_pkg::RESTITUTION_RESET;
    end else if (cfg_we_i) begin
      restitution_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[cci_pkg::LATENCY-2:0], contact_i.valid};
    end
  end

  assign pair.pos_a_x = contact_i.pos_a_x;
  assign pair.pos_a_y = contact_i.pos_a_y;
  assign pair.pos_b_x = contact_i.pos_b_x;
  assign pair.pos_b_y = contact_i.pos_b_y;
  assign pair.vel_a_x = contact_i.vel_a_x;
  assign pair.vel_a_y = contact_i.vel_a_y;
  assign pair.vel_b_x = contact_i.vel_b_x;
  assign pair.vel_b_y = contact_i.vel_b_y;
  assign pair.mass_a  = contact_i.mass_a;
  assign pair.mass_b  = contact_i.mass_b;

  cci_front u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .pair_i (pair),
    .s_o    (s),
    .side_o (fside)
  );

  cci_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .s_i    (s),
    .root_o (root)
  );

  // Hold the side data alongside the square root
  always_ff @(posedge clk_i) begin
    if (en) begin
      line1_q[0] <= fside;
      for (int i = 1; i < cci_pkg::SQRT_STEPS; i++) begin
        line1_q[i] <= line1_q[i-1];
      end
    end
  end

  assign msum = {1'b0, line1_q[cci_pkg::SQRT_STEPS-1].c.ma} +
                {1'b0, line1_q[cci_pkg::SQRT_STEPS-1].c.mb};

  cci_udiv u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({3'b000, line1_q[cci_pkg::SQRT_STEPS-1].ux, 30'd0}),
    .den_i ({1'b0, root}),
    .quo_o (qx),
    .rem_o (rx)
  );

  cci_udiv u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({3'b000, line1_q[cci_pkg::SQRT_STEPS-1].uy, 30'd0}),
    .den_i ({1'b0, root}),
    .quo_o (qy),
    .rem_o (ry)
  );

  cci_udiv u_div_w (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({line1_q[cci_pkg::SQRT_STEPS-1].c.mb, 32'd0}),
    .den_i (msum),
    .quo_o (qw),
    .rem_o (rw)
  );

  always_comb begin
    mid_d.vel_ax = line1_q[cci_pkg::SQRT_STEPS-1].c.vel_ax;
    mid_d.vel_ay = line1_q[cci_pkg::SQRT_STEPS-1].c.vel_ay;
    mid_d.vel_bx = line1_q[cci_pkg::SQRT_STEPS-1].c.vel_bx;
    mid_d.vel_by = line1_q[cci_pkg::SQRT_STEPS-1].c.vel_by;
    mid_d.dvx    = line1_q[cci_pkg::SQRT_STEPS-1].c.dvx;
    mid_d.dvy    = line1_q[cci_pkg::SQRT_STEPS-1].c.dvy;
    mid_d.negx   = line1_q[cci_pkg::SQRT_STEPS-1].negx;
    mid_d.negy   = line1_q[cci_pkg::SQRT_STEPS-1].negy;
    mid_d.deg    = line1_q[cci_pkg::SQRT_STEPS-1].deg;
    mid_d.ma0    = line1_q[cci_pkg::SQRT_STEPS-1].c.ma == '0;
    mid_d.mb0    = line1_q[cci_pkg::SQRT_STEPS-1].c.mb == '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      line2_q[0] <= mid_d;
      for (int i = 1; i < cci_pkg::DIV_STEPS; i++) begin
        line2_q[i] <= line2_q[i-1];
      end
    end
  end

  // Normal quotients never exceed 2^30, so their top bits and remainders drop
  cci_impulse u_impulse (
    .clk_i         (clk_i),
    .en_i          (en),
    .restitution_i (restitution_q),
    .qx_i          (qx[30:0] | {30'd0, ^{qx[32:31], rx, ry, qy[32:31]} & 1'b0}),
    .qy_i          (qy[30:0]),
    .qw_i          (qw),
    .wrem_nz_i     (rw != '0),
    .mid_i         (line2_q[cci_pkg::DIV_STEPS-1]),
    .res_o         (res)
  );

  assign resp_o.valid       = vld_q[cci_pkg::LATENCY-1];
  assign resp_o.new_vel_a_x = res.new_vel_a_x;
  assign resp_o.new_vel_a_y = res.new_vel_a_y;
  assign resp_o.new_vel_b_x = res.new_vel_b_x;
  assign resp_o.new_vel_b_y = res.new_vel_b_y;
  assign resp_o.outcome     = res.outcome;

endmodule

`default_nettype wire

FILE: rtl/cci_checker.sv
// ---------------------------------------------------------------------------
// cci_checker: port-level checks for circle_contact_impulse
// Back-pressure behaviour, output hold and known valids, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module cci_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  outcome,
  input wire logic [31:0] new_vel_a_x
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(new_vel_a_x))
    else $error("result changed while stalled");

  // The pipeline holds whenever the output is stalled
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("pair taken while output stalled");

  // Otherwise a pair is always taken
  a_no_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("pair refused with output free");

  // Handshake valids are always driven to a known level
  a_valid_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_valid, out_valid}))
    else $error("valid unknown");

endmodule

bind circle_contact_impulse cci_checker u_cci_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (contact_i.valid),
  .in_ready    (contact_i.ready),
  .out_valid   (resp_o.valid),
  .out_ready   (resp_o.ready),
  .outcome     (resp_o.outcome),
  .new_vel_a_x (resp_o.new_vel_a_x)
);

`default_nettype wire
